[hdl/trilinear_grid_interpolator_macros.svh]
// Assertion macros shared by the trilinear grid interpolator RTL.
`ifndef TRILINEAR_GRID_INTERPOLATOR_MACROS_SVH
`define TRILINEAR_GRID_INTERPOLATOR_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define TGI_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define TGI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

[hdl/tgi_pkg.sv]
// Shared types and constants of the trilinear grid interpolator.
`timescale 1ns / 1ps

package tgi_pkg;

  localparam int unsigned STORE_DEPTH = 4096;
  localparam int unsigned ADDR_W      = 12;
  localparam int unsigned CFG_W       = 5;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned POS_W       = 17;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned VALUE_W     = 16;

  localparam logic [POS_W-1:0] POS_ONE = 17'h10000;

  localparam logic [CFG_IDX_W-1:0] CFG_VERTS_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTS_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTS_Z = 2'd2;
  localparam logic [CFG_W-1:0]     CFG_VERTS_RESET = 5'd2;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // operand routing of the shared interpolation unit
  typedef enum logic [1:0] {
    MIX_X  = 2'd0,
    MIX_Y0 = 2'd1,
    MIX_Y1 = 2'd2,
    MIX_Z  = 2'd3
  } mix_sel_e;

  typedef struct packed {
    logic     load_en;
    logic     split_en;
    logic     base_en;
    logic     rd_en;
    logic [2:0] corner;
    logic     corner_en;
    logic     mix_en;
    mix_sel_e mix_sel;
    logic     out_load;
  } tgi_cmd_t;

  typedef struct packed {
    logic out_full;
  } tgi_stat_t;

endpackage

[hdl/tgi_ram.sv]
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module tgi_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/tgi_ctrl.sv]
// Sequencer for the trilinear grid interpolator: request decode and query schedule.
`timescale 1ns / 1ps

module tgi_ctrl
  import tgi_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      req_type_i,
  output logic      in_stall_o,
  input  tgi_stat_t stat_i,
  output tgi_cmd_t  cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BASE = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_LAST_READ = 4'd7;
  localparam logic [STEP_W-1:0] STEP_FIRST_CAP = 4'd1;
  localparam logic [STEP_W-1:0] STEP_LAST_CAP  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_FIRST_X   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_LAST_X    = 4'd9;
  localparam logic [STEP_W-1:0] STEP_MIX_Y0    = 4'd10;
  localparam logic [STEP_W-1:0] STEP_MIX_Y1    = 4'd11;
  localparam logic [STEP_W-1:0] STEP_MIX_Z     = 4'd12;
  localparam logic [STEP_W-1:0] STEP_OUT       = 4'd13;

  logic [1:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  tgi_cmd_t          cmd;
  logic              stall;

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    step_d  = step_q;
    stall   = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        stall = 1'b0;
        if (in_valid_i) begin
          if (req_type_i == REQ_QUERY) begin
            cmd.split_en = 1'b1;
            state_d      = ST_BASE;
          end else begin
            cmd.load_en = 1'b1;
          end
        end
      end
      ST_BASE: begin
        cmd.base_en = 1'b1;
        step_d      = '0;
        state_d     = ST_RUN;
      end
      ST_RUN: begin
        // reads issue on steps 0..7 and their data is captured on steps 1..8
        cmd.corner    = step_q[2:0];
        cmd.rd_en     = (step_q <= STEP_LAST_READ);
        cmd.corner_en = (step_q >= STEP_FIRST_CAP) && (step_q <= STEP_LAST_CAP);
        // odd steps 3..9 see a complete corner pair along x
        if (step_q[0] && (step_q >= STEP_FIRST_X) && (step_q <= STEP_LAST_X)) begin
          cmd.mix_en  = 1'b1;
          cmd.mix_sel = MIX_X;
        end
        if (step_q == STEP_MIX_Y0) begin
          cmd.mix_en  = 1'b1;
          cmd.mix_sel = MIX_Y0;
        end
        if (step_q == STEP_MIX_Y1) begin
          cmd.mix_en  = 1'b1;
          cmd.mix_sel = MIX_Y1;
        end
        if (step_q == STEP_MIX_Z) begin
          cmd.mix_en  = 1'b1;
          cmd.mix_sel = MIX_Z;
        end
        if (step_q == STEP_OUT) begin
          if (!stat_i.out_full) begin
            cmd.out_load = 1'b1;
            state_d      = ST_IDLE;
          end
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign cmd_o      = cmd;
  assign in_stall_o = stall;

endmodule

[hdl/tgi_datapath.sv]
// Datapath of the trilinear grid interpolator: config, vertex store, split and interpolation.
`timescale 1ns / 1ps

module tgi_datapath
  import tgi_pkg::*;
#(
  parameter int unsigned MAX_VERTS_PER_AXIS = 16,
  parameter int unsigned VALUE_FRAC_BITS    = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tgi_cmd_t             cmd_i,
  output tgi_stat_t            stat_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic [ADDR_W-1:0]    vertex_addr_i,
  input  logic [VALUE_W-1:0]   vertex_value_i,
  input  logic [POS_W-1:0]     pos_x_i,
  input  logic [POS_W-1:0]     pos_y_i,
  input  logic [POS_W-1:0]     pos_z_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [SAMPLE_W-1:0]  sample_value_o
);

  localparam int unsigned NW  = $clog2(MAX_VERTS_PER_AXIS + 1);
  localparam int unsigned CW  = $clog2(MAX_VERTS_PER_AXIS);
  localparam int unsigned CLW = (NW > CFG_W) ? NW : CFG_W;
  localparam int unsigned SW  = POS_W + NW;
  localparam int unsigned IW  = VALUE_FRAC_BITS + 1;
  localparam int unsigned PW  = IW + POS_W + 2;
  localparam int unsigned UP  = (VALUE_FRAC_BITS > VALUE_W) ? VALUE_FRAC_BITS - VALUE_W : 0;
  localparam int unsigned DN  = (VALUE_FRAC_BITS < VALUE_W) ? VALUE_W - VALUE_FRAC_BITS : 0;

  typedef struct packed {
    logic [CW-1:0]    cell_idx;
    logic [POS_W-1:0] frac;
  } axis_t;

  function automatic logic [NW-1:0] clamp_count(input logic [CFG_W-1:0] v);
    logic [CLW-1:0] w;
    w = CLW'(v);
    if (w < CLW'(2)) begin
      return NW'(2);
    end
    if (w > CLW'(MAX_VERTS_PER_AXIS)) begin
      return NW'(MAX_VERTS_PER_AXIS);
    end
    return NW'(w);
  endfunction

  // scale by n-1, split into cell and fraction; the top edge folds into the last cell
  function automatic axis_t split_axis(input logic [POS_W-1:0] pos, input logic [NW-1:0] n);
    logic [POS_W-1:0] p;
    logic [NW-1:0]    nm1;
    logic [NW-1:0]    nm2;
    logic [SW-1:0]    s;
    logic [NW:0]      idx;
    axis_t            r;
    p   = (pos > POS_ONE) ? POS_ONE : pos;
    nm1 = n - NW'(1);
    nm2 = n - NW'(2);
    s   = SW'(p) * SW'(nm1);
    idx = s[SW-1:16];
    if (idx >= {1'b0, nm1}) begin
      r.cell_idx = nm2[CW-1:0];
      r.frac     = POS_ONE;
    end else begin
      r.cell_idx = idx[CW-1:0];
      r.frac     = {1'b0, s[15:0]};
    end
    return r;
  endfunction

  // configuration
  logic [CFG_W-1:0] cfg_x_q, cfg_y_q, cfg_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_x_q <= CFG_VERTS_RESET;
      cfg_y_q <= CFG_VERTS_RESET;
      cfg_z_q <= CFG_VERTS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_VERTS_X: cfg_x_q <= cfg_wdata_i;
        CFG_VERTS_Y: cfg_y_q <= cfg_wdata_i;
        CFG_VERTS_Z: cfg_z_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [NW-1:0]   nx, ny, nz;
  logic [2*NW-1:0] nxy;

  assign nx  = clamp_count(cfg_x_q);
  assign ny  = clamp_count(cfg_y_q);
  assign nz  = clamp_count(cfg_z_q);
  assign nxy = nx * ny;

  // split and base address
  axis_t             ax_x_q, ax_y_q, ax_z_q;
  logic [ADDR_W-1:0] stride_y_q, stride_z_q, base_q;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] ram_addr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.split_en) begin
      ax_x_q     <= split_axis(pos_x_i, nx);
      ax_y_q     <= split_axis(pos_y_i, ny);
      ax_z_q     <= split_axis(pos_z_i, nz);
      stride_y_q <= ADDR_W'(nx);
      stride_z_q <= ADDR_W'(nxy);
    end
    if (cmd_i.base_en) begin
      // address arithmetic wraps modulo the store depth
      base_q <= ADDR_W'(ADDR_W'(ax_x_q.cell_idx) + ADDR_W'(ax_y_q.cell_idx) * stride_y_q
                        + ADDR_W'(ax_z_q.cell_idx) * stride_z_q);
    end
  end

  // corner order: bit 0 steps x, bit 1 steps z, bit 2 steps y
  assign rd_addr = base_q + (cmd_i.corner[0] ? ADDR_W'(1) : '0)
                 + (cmd_i.corner[2] ? stride_y_q : '0)
                 + (cmd_i.corner[1] ? stride_z_q : '0);

  assign ram_addr = cmd_i.rd_en ? rd_addr : vertex_addr_i;

  logic [VALUE_W-1:0] ram_rdata;

  tgi_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.load_en),
    .addr_i (ram_addr),
    .wdata_i(vertex_value_i),
    .rdata_o(ram_rdata)
  );

  // stored Q0.16 into the internal fraction width
  logic [IW-1:0] vin;

  if (UP > 0) begin : g_in_widen
    assign vin = {1'b0, ram_rdata, {UP{1'b0}}};
  end else if (DN > 0) begin : g_in_narrow
    logic [VALUE_W:0] vin_rnd;
    assign vin_rnd = {1'b0, ram_rdata} + ((VALUE_W + 1)'(1) << (DN - 1));
    assign vin     = vin_rnd[VALUE_W:DN];
  end else begin : g_in_same
    assign vin = {1'b0, ram_rdata};
  end

  logic [IW-1:0] corner_q, prev_q;
  logic [IW-1:0] xs_q [4];
  logic [IW-1:0] y0_q, y1_q;

  // shared interpolation unit: a + (b - a) * f, rounded half up
  logic [IW-1:0]         mix_a, mix_b, mix_r;
  logic [POS_W-1:0]      mix_f;
  logic signed [IW:0]    mix_diff;
  logic signed [PW-1:0]  mix_prod, mix_sum;

  always_comb begin
    case (cmd_i.mix_sel)
      MIX_X: begin
        mix_a = prev_q;
        mix_b = corner_q;
        mix_f = ax_x_q.frac;
      end
      MIX_Y0: begin
        mix_a = xs_q[3];
        mix_b = xs_q[1];
        mix_f = ax_y_q.frac;
      end
      MIX_Y1: begin
        mix_a = xs_q[2];
        mix_b = xs_q[0];
        mix_f = ax_y_q.frac;
      end
      MIX_Z: begin
        mix_a = y0_q;
        mix_b = y1_q;
        mix_f = ax_z_q.frac;
      end
      default: begin
        mix_a = prev_q;
        mix_b = corner_q;
        mix_f = ax_x_q.frac;
      end
    endcase
  end

  assign mix_diff = $signed({1'b0, mix_b}) - $signed({1'b0, mix_a});
  assign mix_prod = mix_diff * $signed({1'b0, mix_f});
  assign mix_sum  = $signed({3'b000, mix_a, 16'h0000}) + mix_prod + $signed(PW'(32768));
  assign mix_r    = mix_sum[IW+15:16];

  always_ff @(posedge clk_i) begin
    if (cmd_i.corner_en) begin
      corner_q <= vin;
      prev_q   <= corner_q;
    end
    if (cmd_i.mix_en) begin
      case (cmd_i.mix_sel)
        MIX_X: begin
          xs_q[0] <= mix_r;
          xs_q[1] <= xs_q[0];
          xs_q[2] <= xs_q[1];
          xs_q[3] <= xs_q[2];
        end
        MIX_Y0:  y0_q <= mix_r;
        MIX_Y1:  y1_q <= mix_r;
        MIX_Z:   y0_q <= mix_r;
        default: ;
      endcase
    end
  end

  // back to Q0.16 with saturation
  logic [SAMPLE_W-1:0] sample_d;

  if (UP > 0) begin : g_out_narrow
    logic [IW:0]    out_rnd;
    logic [IW-UP:0] out_wide;
    assign out_rnd  = {1'b0, y0_q} + ((IW + 1)'(1) << (UP - 1));
    assign out_wide = out_rnd[IW:UP];
    assign sample_d = (|out_wide[IW-UP:SAMPLE_W]) ? '1 : out_wide[SAMPLE_W-1:0];
  end else if (DN > 0) begin : g_out_widen
    logic [SAMPLE_W:0] out_wide;
    assign out_wide = {y0_q, {DN{1'b0}}};
    assign sample_d = out_wide[SAMPLE_W] ? '1 : out_wide[SAMPLE_W-1:0];
  end else begin : g_out_same
    assign sample_d = y0_q[SAMPLE_W] ? '1 : y0_q[SAMPLE_W-1:0];
  end

  logic                out_valid_q;
  logic [SAMPLE_W-1:0] sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      sample_q <= sample_d;
    end
  end

  assign stat_o.out_full = out_valid_q & out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign sample_value_o  = sample_q;

endmodule

[hdl/trilinear_grid_interpolator.sv]
// Top level of the trilinear grid interpolator.
//
//  channel   direction  handshake              payload
//  request   in         in_valid_i/in_stall_o  req_type, vertex_addr, vertex_value, pos_x/y/z
//  result    out        out_valid_o/out_stall_i sample_value
//  config    in         cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// A load request writes its vertex at the accepting edge.
// A query is split at the accepting edge, then computes its base address and issues the 8
// reads from the single-port vertex RAM with the x interpolations trailing behind them,
// then 3 more mixes and the output load, which registers the result.
// Reset restores the vertex counts to 2; the vertex RAM is not cleared.
// A pending result blocks the next query only at its output load step.
`timescale 1ns / 1ps
`include "trilinear_grid_interpolator_macros.svh"

module trilinear_grid_interpolator
  import tgi_pkg::*;
#(
  parameter int unsigned MAX_VERTS_PER_AXIS = 16,
  parameter int unsigned VALUE_FRAC_BITS    = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 req_type_i,
  input  logic [ADDR_W-1:0]    vertex_addr_i,
  input  logic [VALUE_W-1:0]   vertex_value_i,
  input  logic [POS_W-1:0]     pos_x_i,
  input  logic [POS_W-1:0]     pos_y_i,
  input  logic [POS_W-1:0]     pos_z_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [SAMPLE_W-1:0]  sample_value_o
);

  tgi_cmd_t  cmd;
  tgi_stat_t stat;

  tgi_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .req_type_i(req_type_i),
    .in_stall_o(in_stall_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  tgi_datapath #(
    .MAX_VERTS_PER_AXIS(MAX_VERTS_PER_AXIS),
    .VALUE_FRAC_BITS   (VALUE_FRAC_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .vertex_addr_i (vertex_addr_i),
    .vertex_value_i(vertex_value_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sample_value_o(sample_value_o)
  );

  // a query request occupies the block; a load request does not
  `TGI_ASSERT_NEXT(a_query_busy, in_valid_i && !in_stall_o && (req_type_i == REQ_QUERY), in_stall_o)
  `TGI_ASSERT_NEXT(a_load_free, in_valid_i && !in_stall_o && (req_type_i == REQ_LOAD), !in_stall_o)
  // results come only out of a running query
  `TGI_ASSERT_SAME(a_result_src, $rose(out_valid_o), $past(in_stall_o))
  `TGI_ASSERT_NEXT(a_idle_quiet, !in_stall_o && !out_valid_o, !out_valid_o)

endmodule
